>>> sv/lru_page_frame_tracker_defines.svh
// Assertion macros for the LRU page frame tracker.
// Both expect clk and rst_n in scope.
`ifndef LRU_PAGE_FRAME_TRACKER_DEFINES_SVH
`define LRU_PAGE_FRAME_TRACKER_DEFINES_SVH

// same-cycle implication
`define LPFT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lru_pft_pkg.sv
`timescale 1ns / 1ps

package lru_pft_pkg;

  localparam int IN_PAGE_W   = 16;
  localparam int FRAME_OUT_W = 3;
  localparam int CFG_W       = 4;
  localparam int COUNT_W     = 32;
  localparam int OUTCOME_W   = 2;

  localparam logic [CFG_W-1:0]     CFG_RESET = 4'd8;
  localparam logic [COUNT_W-1:0]   COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_COLD = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_MISS = 2'd2;

  typedef struct packed {
    logic hit;
    logic free;
  } lookup_flags_t;

endpackage

>>> sv/lru_pft_lookup.sv
`timescale 1ns / 1ps

module lru_pft_lookup #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 3
) (
  input  logic [FRAMES-1:0]                active,
  input  logic [FRAMES-1:0]                valid,
  input  logic [FRAMES-1:0][PAGE_BITS-1:0] pages,
  input  logic [FRAMES-1:0][IDX_W-1:0]     ranks,
  input  logic [PAGE_BITS-1:0]             page,
  output lru_pft_pkg::lookup_flags_t       flags,
  output logic [IDX_W-1:0]                 hit_idx,
  output logic [IDX_W-1:0]                 free_idx,
  output logic [IDX_W-1:0]                 victim_idx
);

  logic [FRAMES-1:0] hit_vec;
  logic [FRAMES-1:0] free_vec;
  logic [FRAMES-1:0] victim_vec;

  function automatic logic [IDX_W-1:0] first_set(input logic [FRAMES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      free_vec[i] = active[i] && !valid[i];
      hit_vec[i]  = active[i] && valid[i] && (pages[i] == page);
    end
  end

  // oldest active frame: highest rank, lowest index on a tie
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      victim_vec[i] = active[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (active[j] && (j < i) && (ranks[j] >= ranks[i])) begin
          victim_vec[i] = 1'b0;
        end
        if (active[j] && (j > i) && (ranks[j] > ranks[i])) begin
          victim_vec[i] = 1'b0;
        end
      end
    end
  end

  assign flags.hit  = |hit_vec;
  assign flags.free = |free_vec;
  assign hit_idx    = first_set(hit_vec);
  assign free_idx   = first_set(free_vec);
  assign victim_idx = first_set(victim_vec);

endmodule

>>> sv/lru_pft_rank.sv
`timescale 1ns / 1ps

module lru_pft_rank #(
  parameter int FRAMES = 8,
  parameter int IDX_W  = 3
) (
  input  logic [FRAMES-1:0]            valid,
  input  logic [FRAMES-1:0][IDX_W-1:0] ranks,
  input  logic                         fill,
  input  logic [IDX_W-1:0]             sel,
  output logic [FRAMES-1:0][IDX_W-1:0] next_ranks
);

  logic [IDX_W-1:0] sel_rank;

  assign sel_rank = ranks[sel];

  // fill ages every valid frame; touch ages only frames newer than sel
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      next_ranks[i] = ranks[i];
      if (valid[i] && (fill || (ranks[i] < sel_rank))) begin
        next_ranks[i] = ranks[i] + IDX_W'(1);
      end
      if (IDX_W'(i) == sel) begin
        next_ranks[i] = '0;
      end
    end
  end

endmodule

>>> sv/lru_page_frame_tracker.sv
`timescale 1ns / 1ps

// Fully associative page frame set with LRU replacement. One page
// reference is taken per clock (busy never rises). A reference accepted
// at one clock edge has its result on the out_ ports, marked by
// out_strobe, in the next cycle and for exactly one cycle: the tag compare
// and rank update sit between the input register and the result
// register, so back-to-back references need no gap. The receiver
// cannot stall, so results must be captured on the strobe. A reference
// with in_last_in_run set returns the final totals and then clears
// frames, ranks and counts; frames_in_use survives. Write cfg_wr_data
// only while no reference is in flight.
`include "lru_page_frame_tracker_defines.svh"

module lru_page_frame_tracker #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [lru_pft_pkg::IN_PAGE_W-1:0]    in_page_number,
  input  logic                                 in_last_in_run,
  input  logic                                 cfg_wr_en,
  input  logic [lru_pft_pkg::CFG_W-1:0]        cfg_wr_data,
  output logic                                 out_strobe,
  output logic [lru_pft_pkg::OUTCOME_W-1:0]    out_outcome,
  output logic [lru_pft_pkg::FRAME_OUT_W-1:0]  out_frame_index,
  output logic                                 out_counted,
  output logic [lru_pft_pkg::COUNT_W-1:0]      out_miss_total,
  output logic [lru_pft_pkg::COUNT_W-1:0]      out_reference_total,
  output logic                                 out_run_end
);

  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int COUNT_W = lru_pft_pkg::COUNT_W;
  localparam int OUT_W   = lru_pft_pkg::FRAME_OUT_W;

  logic                                  accept;
  logic [PAGE_BITS-1:0]                  in_page_ext;
  logic                                  in_valid_r;
  logic [PAGE_BITS-1:0]                  in_page_r;
  logic                                  in_last_r;
  logic [lru_pft_pkg::CFG_W-1:0]         frames_in_use_r;

  logic [FRAMES-1:0][PAGE_BITS-1:0]      frame_page_r;
  logic [FRAMES-1:0]                     frame_valid_r;
  logic [FRAMES-1:0][IDX_W-1:0]          recency_rank_r;
  logic [FRAMES-1:0][IDX_W-1:0]          recency_rank_nxt;
  logic [COUNT_W-1:0]                    miss_count_r;
  logic [COUNT_W-1:0]                    miss_count_nxt;
  logic [COUNT_W-1:0]                    reference_count_r;
  logic [COUNT_W-1:0]                    reference_count_nxt;

  logic [FRAMES-1:0]                     active;
  lru_pft_pkg::lookup_flags_t            flags;
  logic [IDX_W-1:0]                      hit_idx;
  logic [IDX_W-1:0]                      free_idx;
  logic [IDX_W-1:0]                      victim_idx;
  logic [IDX_W-1:0]                      sel_idx;
  logic                                  fill;
  logic                                  counted;
  logic [lru_pft_pkg::OUTCOME_W-1:0]     outcome;
  logic [OUT_W-1:0]                      frame_out;

  logic                                  out_strobe_r;
  logic [lru_pft_pkg::OUTCOME_W-1:0]     out_outcome_r;
  logic [OUT_W-1:0]                      out_frame_index_r;
  logic                                  out_counted_r;
  logic [COUNT_W-1:0]                    out_miss_total_r;
  logic [COUNT_W-1:0]                    out_reference_total_r;
  logic                                  out_run_end_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  generate
    if (PAGE_BITS <= lru_pft_pkg::IN_PAGE_W) begin : g_page_trunc
      assign in_page_ext = in_page_number[PAGE_BITS-1:0];
    end else begin : g_page_ext
      assign in_page_ext = {{(PAGE_BITS - lru_pft_pkg::IN_PAGE_W){1'b0}}, in_page_number};
    end
    if (IDX_W >= OUT_W) begin : g_idx_trunc
      assign frame_out = sel_idx[OUT_W-1:0];
    end else begin : g_idx_ext
      assign frame_out = {{(OUT_W - IDX_W){1'b0}}, sel_idx};
    end
  endgenerate

  // zero acts as one, values past FRAMES act as FRAMES
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i == 0) || (i < int'(frames_in_use_r));
    end
  end

  lru_pft_lookup #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W)
  ) u_lookup (
    .active     (active),
    .valid      (frame_valid_r),
    .pages      (frame_page_r),
    .ranks      (recency_rank_r),
    .page       (in_page_r),
    .flags      (flags),
    .hit_idx    (hit_idx),
    .free_idx   (free_idx),
    .victim_idx (victim_idx)
  );

  assign fill    = flags.free && !flags.hit;
  assign counted = !flags.free;
  assign sel_idx = flags.hit ? hit_idx : (flags.free ? free_idx : victim_idx);

  always_comb begin
    if (flags.hit) begin
      outcome = lru_pft_pkg::OUTCOME_HIT;
    end else if (flags.free) begin
      outcome = lru_pft_pkg::OUTCOME_COLD;
    end else begin
      outcome = lru_pft_pkg::OUTCOME_MISS;
    end
  end

  lru_pft_rank #(
    .FRAMES (FRAMES),
    .IDX_W  (IDX_W)
  ) u_rank (
    .valid      (frame_valid_r),
    .ranks      (recency_rank_r),
    .fill       (fill),
    .sel        (sel_idx),
    .next_ranks (recency_rank_nxt)
  );

  always_comb begin
    reference_count_nxt = reference_count_r;
    miss_count_nxt      = miss_count_r;
    if (counted && (reference_count_r != lru_pft_pkg::COUNT_MAX)) begin
      reference_count_nxt = reference_count_r + COUNT_W'(1);
    end
    if (counted && !flags.hit && (miss_count_r != lru_pft_pkg::COUNT_MAX)) begin
      miss_count_nxt = miss_count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_strobe_r      <= 1'b0;
      frames_in_use_r   <= lru_pft_pkg::CFG_RESET;
      frame_valid_r     <= '0;
      recency_rank_r    <= '0;
      miss_count_r      <= '0;
      reference_count_r <= '0;
    end else begin
      in_valid_r   <= accept;
      out_strobe_r <= in_valid_r;
      if (cfg_wr_en) begin
        frames_in_use_r <= cfg_wr_data;
      end
      if (in_valid_r) begin
        if (in_last_r) begin
          frame_valid_r     <= '0;
          recency_rank_r    <= '0;
          miss_count_r      <= '0;
          reference_count_r <= '0;
        end else begin
          frame_valid_r[sel_idx] <= 1'b1;
          recency_rank_r         <= recency_rank_nxt;
          miss_count_r           <= miss_count_nxt;
          reference_count_r      <= reference_count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_page_r <= in_page_ext;
      in_last_r <= in_last_in_run;
    end
    if (in_valid_r) begin
      if (!flags.hit) begin
        frame_page_r[sel_idx] <= in_page_r;
      end
      out_outcome_r         <= outcome;
      out_frame_index_r     <= frame_out;
      out_counted_r         <= counted;
      out_miss_total_r      <= miss_count_nxt;
      out_reference_total_r <= reference_count_nxt;
      out_run_end_r         <= in_last_r;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_outcome         = out_outcome_r;
  assign out_frame_index     = out_frame_index_r;
  assign out_counted         = out_counted_r;
  assign out_miss_total      = out_miss_total_r;
  assign out_reference_total = out_reference_total_r;
  assign out_run_end         = out_run_end_r;

  `LPFT_ASSERT_NEXT(a_strobe_follows_input, in_valid_r, out_strobe_r,
                    "transaction lost between stages")
  `LPFT_ASSERT_NEXT(a_no_spurious_strobe, !in_valid_r, !out_strobe_r,
                    "result without transaction")
  `LPFT_ASSERT_SAME(a_miss_is_counted,
                    out_strobe_r && (out_outcome_r == lru_pft_pkg::OUTCOME_MISS),
                    out_counted_r, "replacement miss while frames free")
  `LPFT_ASSERT_SAME(a_cold_not_counted,
                    out_strobe_r && (out_outcome_r == lru_pft_pkg::OUTCOME_COLD),
                    !out_counted_r, "cold fill was counted")
  `LPFT_ASSERT_SAME(a_run_end_clears, out_strobe_r && out_run_end_r,
                    (frame_valid_r == '0) && (reference_count_r == '0),
                    "state not cleared after run end")

endmodule
